// File: sv/kscr_pkg.sv
package kscr_pkg;

	localparam int KEY_W       = 12;
	localparam int KEY_IDX_W   = 4;
	localparam int SAMPLE_W    = 10;
	localparam int LVL_W       = 3;
	localparam int PREV_LVL_W  = 4;
	localparam int BYTE_W      = 6;
	localparam int PEND_W      = KEY_W + 2;
	localparam int PEND_IDX_W  = $clog2(PEND_W);
	localparam int STICK_A_POS = KEY_W;
	localparam int STICK_B_POS = KEY_W + 1;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [PREV_LVL_W-1:0] LEVEL_RESET = 4'h8;
	localparam logic [1:0]            PFX_STICK_A = 2'b10;
	localparam logic [1:0]            PFX_STICK_B = 2'b11;

	localparam int DEF_ROWS         = 3;
	localparam int DEF_COLUMNS      = 4;
	localparam int DEF_DEAD_BAND    = 64;
	localparam int DEF_REPEAT_COUNT = 3;

	// one scan that caused at least one event
	typedef struct packed {
		logic [KEY_W-1:0]  keys;
		logic [PEND_W-1:0] pend;
		logic [LVL_W-1:0]  level_a;
		logic [LVL_W-1:0]  level_b;
	} job_t;

endpackage

// File: sv/kscr_front.sv
module kscr_front
	import kscr_pkg::*;
#(
	parameter int ROWS      = DEF_ROWS,
	parameter int COLUMNS   = DEF_COLUMNS,
	parameter int DEAD_BAND = DEF_DEAD_BAND
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [KEY_W-1:0]    key_bits,
	input  logic [SAMPLE_W-1:0] stick_a_sample,
	input  logic [SAMPLE_W-1:0] stick_b_sample,
	input  logic                q_full,
	output logic                q_push,
	output job_t                q_data
);

	localparam int KEY_TOTAL = ROWS * COLUMNS;
	localparam int KEY_LIMIT = (KEY_TOTAL >= KEY_W) ? KEY_W : KEY_TOTAL;
	localparam logic [KEY_W-1:0] KEY_MASK =
		(KEY_LIMIT >= KEY_W) ? {KEY_W{1'b1}} : KEY_W'((1 << KEY_LIMIT) - 1);
	localparam int SPAN_RAW = 511 - 2 * DEAD_BAND;
	localparam int SPAN     = (SPAN_RAW < 1) ? 1 : SPAN_RAW;
	localparam logic signed [13:0] DB   = 14'(DEAD_BAND);
	localparam logic signed [13:0] MID  = 14'(512 + DEAD_BAND);
	localparam logic signed [13:0] TH1  = 14'(SPAN);
	localparam logic signed [13:0] TH2  = 14'(2 * SPAN);
	localparam logic signed [13:0] TH3  = 14'(3 * SPAN);

	logic [KEY_W-1:0]      prev_keys_q;
	logic [PREV_LVL_W-1:0] prev_level_a_q;
	logic [PREV_LVL_W-1:0] prev_level_b_q;

	logic [KEY_W-1:0] keys;
	logic [KEY_W-1:0] diff;
	logic [LVL_W-1:0] level_a;
	logic [LVL_W-1:0] level_b;
	logic             chg_a;
	logic             chg_b;
	logic             accept;

	// clamp(trunc(3*v/span), 0, 3) is the number of thresholds k*span that 3*v reaches
	function automatic logic [1:0] term(input logic signed [13:0] v);
		logic signed [13:0] v3;
		v3 = v * 14'sd3;
		return 2'({1'b0, (v3 >= TH1)} + {1'b0, (v3 >= TH2)} + {1'b0, (v3 >= TH3)});
	endfunction

	function automatic logic [LVL_W-1:0] level(input logic [SAMPLE_W-1:0] x);
		logic signed [13:0] xs;
		logic [1:0]         t1;
		logic [1:0]         t2;
		xs = $signed({4'b0, x});
		t1 = term(xs - DB);
		t2 = term(xs - MID);
		return 3'd6 - {1'b0, t1} - {1'b0, t2};
	endfunction

	always_comb begin
		keys    = key_bits & KEY_MASK;
		diff    = keys ^ prev_keys_q;
		level_a = level(stick_a_sample);
		level_b = level(stick_b_sample);
		chg_a   = {1'b0, level_a} != prev_level_a_q;
		chg_b   = {1'b0, level_b} != prev_level_b_q;
		in_ready = !q_full;
		accept   = in_valid && in_ready;

		q_data.keys    = keys;
		q_data.pend    = {chg_b, chg_a, diff};
		q_data.level_a = level_a;
		q_data.level_b = level_b;
		// a scan without changes produces nothing downstream
		q_push = accept && (q_data.pend != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_keys_q    <= '0;
			prev_level_a_q <= LEVEL_RESET;
			prev_level_b_q <= LEVEL_RESET;
		end else if (accept) begin
			prev_keys_q    <= keys;
			prev_level_a_q <= {1'b0, level_a};
			prev_level_b_q <= {1'b0, level_b};
		end
	end

endmodule

// File: sv/kscr_queue.sv
module kscr_queue
	import kscr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	input  logic pop,
	output job_t pop_data,
	output logic full,
	output logic empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = count_q == CNT_W'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign pop_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("queue read while empty");
`endif

endmodule

// File: sv/kscr_back.sv
module kscr_back
	import kscr_pkg::*;
#(
	parameter int REPEAT_COUNT = DEF_REPEAT_COUNT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  job_t              q_data,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] event_byte,
	output logic              last_of_scan
);

	localparam int REP_W = (REPEAT_COUNT > 1) ? $clog2(REPEAT_COUNT) : 1;

	logic                  busy_q;
	logic [PEND_W-1:0]     mask_q;
	logic [KEY_W-1:0]      keys_q;
	logic [LVL_W-1:0]      level_a_q;
	logic [LVL_W-1:0]      level_b_q;
	logic [REP_W-1:0]      rep_q;
	logic                  out_valid_q;
	logic [BYTE_W-1:0]     byte_q;
	logic                  last_q;

	logic                  advance;
	logic                  emit;
	logic                  rep_last;
	logic [PEND_IDX_W-1:0] idx;
	logic [PEND_W-1:0]     pend_next;
	logic [BYTE_W-1:0]     byte_d;
	logic                  last_d;

	// lowest pending event goes first: keys in index order, then stick a, then stick b
	always_comb begin
		idx = '0;
		for (int i = PEND_W - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				idx = PEND_IDX_W'(i);
			end
		end
		pend_next      = mask_q;
		pend_next[idx] = 1'b0;

		if (idx == PEND_IDX_W'(STICK_A_POS)) begin
			byte_d = {PFX_STICK_A, 1'b0, level_a_q};
		end else if (idx == PEND_IDX_W'(STICK_B_POS)) begin
			byte_d = {PFX_STICK_B, 1'b0, level_b_q};
		end else begin
			byte_d = {1'b0, keys_q[idx[KEY_IDX_W-1:0]], idx[KEY_IDX_W-1:0]};
		end

		advance  = !out_valid_q || out_ready;
		emit     = advance && busy_q;
		q_pop    = advance && !busy_q && !q_empty;
		rep_last = rep_q == REP_W'(REPEAT_COUNT - 1);
		last_d   = rep_last && (pend_next == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			mask_q      <= '0;
			rep_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= busy_q;
			if (busy_q) begin
				if (rep_last) begin
					rep_q  <= '0;
					mask_q <= pend_next;
					busy_q <= pend_next != '0;
				end else begin
					rep_q <= rep_q + 1'b1;
				end
			end else if (q_pop) begin
				mask_q <= q_data.pend;
				busy_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			keys_q    <= q_data.keys;
			level_a_q <= q_data.level_a;
			level_b_q <= q_data.level_b;
		end
		if (emit) begin
			byte_q <= byte_d;
			last_q <= last_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_byte   = byte_q;
	assign last_of_scan = last_q;

`ifndef ASSERT_OFF
	a_busy_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (mask_q != '0))
		else $error("sequencer busy with nothing pending");
	a_rep_range: assert property (@(posedge clk) disable iff (!arst_n)
		rep_q <= REP_W'(REPEAT_COUNT - 1))
		else $error("repeat counter out of range");
	a_last_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last_d) |=> (!busy_q && out_valid_q && last_q))
		else $error("last beat of a scan did not end the job");
	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (busy_q && !out_valid_q))
		else $error("job load did not start the sequencer");
`endif

endmodule

// File: sv/keypad_stick_change_reporter.sv
// a scan's first beat goes through the job queue, the job load and the output register
// one beat per cycle but for out_ready stalls and job loads; REPEAT_COUNT beats per event
// the back end works on one scan at a time; a 2-deep job queue lets scans be taken meanwhile
// a scan with no change produces no beat and is not queued
// reset: asynchronous, clears the queue and output; previous keys go to zero, levels to 8
module keypad_stick_change_reporter
	import kscr_pkg::*;
#(
	parameter int ROWS         = DEF_ROWS,
	parameter int COLUMNS      = DEF_COLUMNS,
	parameter int DEAD_BAND    = DEF_DEAD_BAND,
	parameter int REPEAT_COUNT = DEF_REPEAT_COUNT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [KEY_W-1:0]    key_bits,
	input  logic [SAMPLE_W-1:0] stick_a_sample,
	input  logic [SAMPLE_W-1:0] stick_b_sample,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [BYTE_W-1:0]   event_byte,
	output logic                last_of_scan
);

	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;
	job_t q_wdata;
	job_t q_rdata;

	kscr_front #(
		.ROWS      (ROWS),
		.COLUMNS   (COLUMNS),
		.DEAD_BAND (DEAD_BAND)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.key_bits       (key_bits),
		.stick_a_sample (stick_a_sample),
		.stick_b_sample (stick_b_sample),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_data         (q_wdata)
	);

	kscr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.full      (q_full),
		.empty     (q_empty)
	);

	kscr_back #(
		.REPEAT_COUNT (REPEAT_COUNT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_data       (q_rdata),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_byte   (event_byte),
		.last_of_scan (last_of_scan)
	);

endmodule
